FILE: src/fla_pkg.sv
package fla_pkg;

  // Sizes of the slot pool and of the counters.
  localparam int unsigned MaxSlots = 256;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned CntW     = 9;
  localparam int unsigned ActW     = 2;
  localparam int unsigned StatW    = 2;

  // Capacity register value after hardware reset.
  localparam logic [CntW-1:0] CapReset = CntW'(256);

  // Request action codes.
  typedef enum logic [ActW-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_RESET = 2'd2
  } action_e;

  // Response status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_CLEAR = 2'd2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
    logic clear;
  } cmd_t;

endpackage

FILE: src/fla_req_if.sv
interface fla_req_if;
  logic                        valid;
  logic                        ready;
  logic [fla_pkg::ActW-1:0]    action;
  logic [fla_pkg::IdxW-1:0]    slot_index;

  modport source (output valid, output action, output slot_index, input ready);
  modport sink   (input valid, input action, input slot_index, output ready);
endinterface

FILE: src/fla_rsp_if.sv
interface fla_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fla_pkg::StatW-1:0]   status;
  logic [fla_pkg::IdxW-1:0]    granted_index;
  logic [fla_pkg::CntW-1:0]    free_slots;
  logic [fla_pkg::CntW-1:0]    used_slots;

  modport source (output valid, output status, output granted_index,
                  output free_slots, output used_slots, input ready);
  modport sink   (input valid, input status, input granted_index,
                  input free_slots, input used_slots, output ready);
endinterface

FILE: src/fla_ctrl.sv
module fla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  logic          clear_last_i,
  input  logic          reset_act_i,
  output fla_pkg::cmd_t cmd_o
);

  fla_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // The response register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || rsp_ready_i;

  // Next state. A reset action is followed by a walk that clears the flags.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fla_pkg::S_IDLE: begin
        if (req_valid_i) state_d = fla_pkg::S_EXEC;
      end
      fla_pkg::S_EXEC: begin
        if (out_free) state_d = reset_act_i ? fla_pkg::S_CLEAR : fla_pkg::S_IDLE;
      end
      fla_pkg::S_CLEAR: begin
        if (clear_last_i) state_d = fla_pkg::S_IDLE;
      end
      default: state_d = fla_pkg::S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    req_ready_o    = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    cmd_o.clear    = 1'b0;
    unique case (state_q)
      fla_pkg::S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      fla_pkg::S_EXEC: begin
        cmd_o.commit = out_free;
      end
      fla_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  // Response valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // After hardware reset the flags are cleared before the first request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fla_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A captured request always moves on to execute, so it is committed before the next one is taken.
  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == fla_pkg::S_EXEC)
    else $error("capture did not move to execute");

  // A commit never overwrites a result that is still waiting.
  a_commit_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || rsp_ready_i))
    else $error("commit overwrote a pending result");

  // No request is taken while the flags are being cleared.
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fla_pkg::S_CLEAR |-> !req_ready_o)
    else $error("request accepted during the clearing walk");
`endif

endmodule

FILE: src/fla_dp.sv
module fla_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fla_pkg::cmd_t               cmd_i,
  input  logic [fla_pkg::ActW-1:0]    action_i,
  input  logic [fla_pkg::IdxW-1:0]    slot_index_i,
  input  logic                        cfg_we_i,
  input  logic [fla_pkg::CntW-1:0]    cfg_wdata_i,
  output logic [fla_pkg::StatW-1:0]   status_o,
  output logic [fla_pkg::IdxW-1:0]    granted_index_o,
  output logic [fla_pkg::CntW-1:0]    free_slots_o,
  output logic [fla_pkg::CntW-1:0]    used_slots_o,
  output logic                        clear_last_o,
  output logic                        reset_act_o
);

  localparam logic [fla_pkg::CntW-1:0] MaxCnt = fla_pkg::CntW'(fla_pkg::MaxSlots);
  localparam logic [fla_pkg::CntW-1:0] OneCnt = fla_pkg::CntW'(1);
  localparam logic [fla_pkg::IdxW-1:0] OneIdx  = fla_pkg::IdxW'(1);
  localparam logic [fla_pkg::IdxW-1:0] LastIdx = fla_pkg::IdxW'(fla_pkg::MaxSlots - 1);

  // Stack memory of free indices.
  logic [fla_pkg::IdxW-1:0] stack_mem [fla_pkg::MaxSlots];
  logic [fla_pkg::IdxW-1:0] rd_q;
  logic [fla_pkg::IdxW-1:0] rd_addr;

  // Active flag memory and its clearing walk.
  logic                     flag_mem [fla_pkg::MaxSlots];
  logic                     flag_rd_q;
  logic [fla_pkg::IdxW-1:0] clr_q;
  logic                     flag_we;
  logic                     flag_wdata;
  logic [fla_pkg::IdxW-1:0] flag_waddr;

  // Control state.
  logic [fla_pkg::CntW-1:0]     cap_q;
  logic [fla_pkg::CntW-1:0]     wcap_q, wcap_d;
  logic [fla_pkg::CntW-1:0]     ft_q, ft_d;
  logic [fla_pkg::CntW-1:0]     at_q, at_d;
  logic [fla_pkg::CntW-1:0]     wm_q, wm_d;

  // Captured request.
  fla_pkg::action_e         act_q;
  logic [fla_pkg::IdxW-1:0] slot_q;

  // Response payload.
  fla_pkg::status_e         status_q, status_d;
  logic [fla_pkg::IdxW-1:0] grant_q, grant_d;

  logic [fla_pkg::CntW-1:0] top_pos;
  logic [fla_pkg::CntW-1:0] cap_clamped;
  logic [fla_pkg::IdxW-1:0] alloc_idx;
  logic                     push_en;

  // Capacity register, clamped into the legal range when it takes effect.
  always_comb begin
    priority if (cap_q == '0) begin
      cap_clamped = OneCnt;
    end else if (cap_q > MaxCnt) begin
      cap_clamped = MaxCnt;
    end else begin
      cap_clamped = cap_q;
    end
  end

  // Position of the top free entry. Entries below the low-water mark were
  // never rewritten since the last refill, so their index is computed from the capacity.
  assign top_pos   = ft_q - OneCnt;
  assign rd_addr   = top_pos[fla_pkg::IdxW-1:0];
  assign alloc_idx = (top_pos < wm_q) ? fla_pkg::IdxW'(wcap_q - OneCnt - top_pos) : rd_q;

  // Execute the captured request.
  always_comb begin
    wcap_d     = wcap_q;
    ft_d       = ft_q;
    at_d       = at_q;
    wm_d       = wm_q;
    status_d   = fla_pkg::ST_OK;
    grant_d    = '0;
    push_en    = 1'b0;
    flag_we    = 1'b0;
    flag_waddr = alloc_idx;
    flag_wdata = 1'b1;
    unique case (act_q)
      fla_pkg::ACT_ALLOC: begin
        if (ft_q == '0) begin
          status_d = fla_pkg::ST_EMPTY;
        end else begin
          ft_d       = top_pos;
          at_d       = at_q + OneCnt;
          flag_we    = 1'b1;
          flag_waddr = alloc_idx;
          flag_wdata = 1'b1;
          grant_d    = alloc_idx;
        end
      end
      fla_pkg::ACT_FREE: begin
        priority if ({1'b0, slot_q} >= wcap_q) begin
          status_d = fla_pkg::ST_REJECT;
        end else if (!flag_rd_q) begin
          status_d = fla_pkg::ST_REJECT;
        end else if (ft_q >= wcap_q) begin
          status_d = fla_pkg::ST_REJECT;
        end else begin
          push_en    = 1'b1;
          flag_we    = 1'b1;
          flag_waddr = slot_q;
          flag_wdata = 1'b0;
          ft_d       = ft_q + OneCnt;
          wm_d       = (ft_q < wm_q) ? ft_q : wm_q;
          if (at_q != '0) at_d = at_q - OneCnt;
        end
      end
      fla_pkg::ACT_RESET: begin
        wcap_d = cap_clamped;
        ft_d   = cap_clamped;
        at_d   = '0;
        wm_d   = MaxCnt;
      end
      default: begin
        status_d = fla_pkg::ST_OK;
      end
    endcase
  end

  // Stack memory: read on capture, push on commit of a free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= stack_mem[rd_addr];
    end
    if (cmd_i.commit && push_en) begin
      stack_mem[ft_q[fla_pkg::IdxW-1:0]] <= slot_q;
    end
  end

  // Flag memory: read on capture, written on commit or by the clearing walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      flag_rd_q <= flag_mem[slot_index_i];
    end
    if (cmd_i.clear) begin
      flag_mem[clr_q] <= 1'b0;
    end else if (cmd_i.commit && flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
  end

  // Request capture and response payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= fla_pkg::action_e'(action_i);
      slot_q <= slot_index_i;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      grant_q  <= grant_d;
    end
  end

  // Pool state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= fla_pkg::CapReset;
      wcap_q   <= fla_pkg::CapReset;
      ft_q     <= fla_pkg::CapReset;
      at_q     <= '0;
      wm_q     <= MaxCnt;
      clr_q    <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.clear) clr_q <= clr_q + OneIdx;
      if (cmd_i.commit) begin
        wcap_q   <= wcap_d;
        ft_q     <= ft_d;
        at_q     <= at_d;
        wm_q     <= wm_d;
      end
    end
  end

  assign status_o        = status_q;
  assign granted_index_o = grant_q;
  assign free_slots_o    = ft_q;
  assign used_slots_o    = at_q;
  assign clear_last_o    = (clr_q == LastIdx);
  assign reset_act_o     = (act_q == fla_pkg::ACT_RESET);

`ifndef NO_ASSERTIONS
  // Every managed slot is either on the free stack or active.
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ft_q + at_q) == wcap_q)
    else $error("free and active counts do not add up to capacity");

  // The clearing walk always ends back at the first slot.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> clr_q == '0)
    else $error("request captured before the clearing walk finished");

  // A granted slot has its active flag written on the commit.
  a_grant_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && act_q == fla_pkg::ACT_ALLOC && ft_q != '0)
      |-> (flag_we && flag_wdata && flag_waddr == grant_d))
    else $error("granted slot not marked active");
`endif

endmodule

FILE: src/free_list_index_allocator_top.sv
// Free-list slot index allocator.
// The request is captured together with the stack and flag reads, then executed and
// committed to the response register once that register is free.
// A new request is taken only after the last one is committed, capture then execute.
// Reset: asynchronous; the pool comes up full with 256 slots, index 0 first, after a pass
// that clears the active flags. A reset action answers as any other request and then
// holds off requests while it clears the flags.
module free_list_index_allocator_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  fla_req_if.sink                  req_i,
  fla_rsp_if.source                rsp_o,
  input  logic                     cfg_we_i,
  input  logic [fla_pkg::CntW-1:0] cfg_wdata_i
);

  fla_pkg::cmd_t cmd;
  logic          req_ready;
  logic          rsp_valid;
  logic          clear_last;
  logic          reset_act;

  // Sequencing of request capture and commit.
  fla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_ready),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_o.ready),
    .clear_last_i (clear_last),
    .reset_act_i  (reset_act),
    .cmd_o        (cmd)
  );

  // Stack, counters and active flags.
  fla_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (req_i.action),
    .slot_index_i    (req_i.slot_index),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .status_o        (rsp_o.status),
    .granted_index_o (rsp_o.granted_index),
    .free_slots_o    (rsp_o.free_slots),
    .used_slots_o    (rsp_o.used_slots),
    .clear_last_o    (clear_last),
    .reset_act_o     (reset_act)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

endmodule

FILE: test/free_list_index_allocator_top_tb.sv
module free_list_index_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fla_pkg::*;

  // Unused action code: the block must leave its state alone and answer OK.
  localparam logic [ActW-1:0] ActUnused = 2'd3;

  localparam int unsigned LongHold   = 300;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainWait  = 10;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [IdxW-1:0] slot;
  } slot_req_t;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] granted;
    logic [CntW-1:0] free_slots;
    logic [CntW-1:0] used_slots;
  } alloc_rsp_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;

  fla_req_if req_if ();
  fla_rsp_if rsp_if ();

  free_list_index_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the allocator state.
  logic [IdxW-1:0] shadow_stack [MaxSlots];
  logic            slot_busy    [MaxSlots];
  int unsigned     free_cnt;
  int unsigned     used_cnt;
  int unsigned     pool_cap;
  logic [CntW-1:0] cap_reg;

  slot_req_t  pending_reqs  [$];
  alloc_rsp_t expected_rsps [$];

  int unsigned error_count    = 0;
  int unsigned reqs_sent      = 0;
  int unsigned rsps_checked   = 0;
  int unsigned empty_seen     = 0;
  int unsigned reject_seen    = 0;
  int unsigned settings_count = 0;
  int unsigned cycle_count    = 0;

  bit   send_idle_on = 1'b1;
  bit   recv_idle_on = 1'b1;
  logic rsp_hold_kick = 1'b0;

  // Refill the free stack so that index 0 is on top, and clear every flag.
  function automatic void restock_pool();
    pool_cap = (cap_reg == 0) ? 1 : ((cap_reg > MaxSlots) ? MaxSlots : cap_reg);
    for (int i = 0; i < MaxSlots; i++) begin
      shadow_stack[i] = (i < pool_cap) ? IdxW'(pool_cap - 1 - i) : '0;
      slot_busy[i]    = 1'b0;
    end
    free_cnt = pool_cap;
    used_cnt = 0;
  endfunction

  // Apply one request to the shadow state and return the response it causes.
  function automatic alloc_rsp_t next_alloc_rsp(input slot_req_t req);
    alloc_rsp_t      rsp;
    logic [IdxW-1:0] top;
    rsp.status  = ST_OK;
    rsp.granted = '0;
    case (req.action)
      ACT_ALLOC: begin
        if (free_cnt == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          free_cnt--;
          top            = shadow_stack[free_cnt];
          slot_busy[top] = 1'b1;
          used_cnt++;
          rsp.granted = top;
        end
      end
      ACT_FREE: begin
        // Bounds first, then the active flag, then a full stack.
        if (req.slot >= pool_cap || !slot_busy[req.slot] || free_cnt >= pool_cap) begin
          rsp.status = ST_REJECT;
        end else begin
          slot_busy[req.slot]    = 1'b0;
          shadow_stack[free_cnt] = req.slot;
          free_cnt++;
          if (used_cnt > 0) used_cnt--;
        end
      end
      ACT_RESET: begin
        restock_pool();
      end
      default: begin
      end
    endcase
    rsp.free_slots = CntW'(free_cnt);
    rsp.used_slots = CntW'(used_cnt);
    return rsp;
  endfunction

  function automatic int unsigned draw_gap(input bit idle_on);
    return idle_on ? $urandom_range(0, 15) : 0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s in response %0d: got %0d, expected %0d",
             $realtime, what, rsps_checked, got, want);
    error_count++;
  endtask

  // Clock and cycle limit.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Request driver: takes the next pending request after its idle gap.
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit        offer;
    slot_req_t item;
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.action     <= '0;
      req_if.slot_index <= '0;
      send_gap = 0;
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        item.action = req_if.action;
        item.slot   = req_if.slot_index;
        expected_rsps.push_back(next_alloc_rsp(item));
        reqs_sent++;
        offer    = 1'b0;
        send_gap = draw_gap(send_idle_on);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          item = pending_reqs.pop_front();
          offer = 1'b1;
          req_if.action     <= item.action;
          req_if.slot_index <= item.slot;
        end
      end
      req_if.valid <= offer;
    end
  end

  // Response monitor: random stalls per response, plus one long hold-off on request.
  int unsigned recv_stall = 0;
  int unsigned hold_left  = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want;
    bit         rdy;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_stall = 0;
      hold_left  = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("[%0t] response with no request waiting", $realtime);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.status != want.status)
            report_mismatch("status", rsp_if.status, want.status);
          if (rsp_if.granted_index != want.granted)
            report_mismatch("granted_index", rsp_if.granted_index, want.granted);
          if (rsp_if.free_slots != want.free_slots)
            report_mismatch("free_slots", rsp_if.free_slots, want.free_slots);
          if (rsp_if.used_slots != want.used_slots)
            report_mismatch("used_slots", rsp_if.used_slots, want.used_slots);
          if (want.status == ST_EMPTY) empty_seen++;
          if (want.status == ST_REJECT) reject_seen++;
          rsps_checked++;
        end
        recv_stall = draw_gap(recv_idle_on);
      end
      if (rsp_hold_kick) hold_left = LongHold;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_if.ready <= rdy;
    end
  end

  task automatic queue_req(input logic [ActW-1:0] act, input logic [IdxW-1:0] slot);
    slot_req_t item;
    item.action = act;
    item.slot   = slot;
    pending_reqs.push_back(item);
  endtask

  // Wait until the sender is empty and every response has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
  endtask

  task automatic write_capacity(input logic [CntW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cap_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  // Pick a slot the shadow state holds active, as a hint for a valid free.
  function automatic logic [IdxW-1:0] pick_busy_slot();
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, pool_cap - 1);
    for (int k = 0; k < pool_cap; k++) begin
      idx = (start + k) % pool_cap;
      if (slot_busy[idx]) return IdxW'(idx);
    end
    return IdxW'($urandom_range(0, MaxSlots - 1));
  endfunction

  task automatic queue_random_req(input int unsigned alloc_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      queue_req(ACT_RESET, IdxW'($urandom));
    end else if (roll < 5) begin
      queue_req(ActUnused, IdxW'($urandom));
    end else if ($urandom_range(0, 99) < alloc_pct) begin
      queue_req(ACT_ALLOC, IdxW'($urandom));
    end else if ($urandom_range(0, 99) < 80) begin
      queue_req(ACT_FREE, pick_busy_slot());
    end else begin
      queue_req(ACT_FREE, IdxW'($urandom));
    end
  endtask

  // One setting of the capacity: write it, restart the pool, then random traffic.
  task automatic run_phase(input logic [CntW-1:0] cap_value, input int unsigned n_items,
                           input int unsigned alloc_pct, input bit long_hold,
                           input bit mid_pause);
    wait_idle();
    write_capacity(cap_value);
    send_idle_on = ($urandom_range(0, 3) != 0);
    recv_idle_on = ($urandom_range(0, 3) != 0);
    queue_req(ACT_RESET, IdxW'($urandom));
    if (long_hold) begin
      @(posedge clk_i);
      rsp_hold_kick <= 1'b1;
      @(posedge clk_i);
      rsp_hold_kick <= 1'b0;
    end
    for (int i = 0; i < n_items; i++) begin
      while (pending_reqs.size() >= 2) @(negedge clk_i);
      if (mid_pause && i == n_items / 2) wait_idle();
      queue_random_req(alloc_pct);
    end
  endtask

  // Reset, directed cases, then randomized phases over several capacities.
  initial begin
    rst_ni  = 1'b0;
    cap_reg = CapReset;
    restock_pool();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full pool of 256 after reset: grant order, double free, inactive slot.
    queue_req(ACT_ALLOC, 8'h00);
    queue_req(ACT_ALLOC, 8'hFF);
    queue_req(ACT_FREE, 8'd1);
    queue_req(ACT_FREE, 8'd1);
    queue_req(ACT_FREE, 8'd255);
    queue_req(ActUnused, 8'hAA);
    queue_req(ACT_FREE, 8'd0);
    queue_req(ACT_ALLOC, 8'h55);
    queue_req(ACT_RESET, 8'h55);
    queue_req(ACT_ALLOC, 8'h00);
    wait_idle();

    // Smallest pool: empty alloc and out-of-range free.
    write_capacity(CntW'(1));
    queue_req(ACT_RESET, 8'h00);
    queue_req(ACT_ALLOC, 8'h00);
    queue_req(ACT_ALLOC, 8'h00);
    queue_req(ACT_FREE, 8'd1);
    queue_req(ACT_FREE, 8'd0);
    queue_req(ACT_FREE, 8'd0);
    queue_req(ActUnused, 8'hFF);
    wait_idle();

    // A capacity of zero is taken as one.
    write_capacity(CntW'(0));
    queue_req(ACT_RESET, 8'h00);
    queue_req(ACT_ALLOC, 8'h00);
    queue_req(ACT_ALLOC, 8'h00);
    queue_req(ACT_FREE, 8'd255);
    wait_idle();

    // Above the maximum is taken as the maximum, and only at the next reset action.
    write_capacity(CntW'(511));
    queue_req(ACT_ALLOC, 8'h00);
    queue_req(ACT_RESET, 8'h00);
    queue_req(ACT_ALLOC, 8'h00);
    queue_req(ACT_FREE, 8'd128);

    run_phase(CntW'(2), 40, 50, 1'b1, 1'b0);
    run_phase(CntW'(256), 40, 50, 1'b0, 1'b1);
    run_phase(CntW'(5), 40, 60, 1'b0, 1'b0);
    run_phase(CntW'(0), 40, 40, 1'b0, 1'b0);
    run_phase(CntW'(17), 40, 50, 1'b1, 1'b0);
    run_phase(CntW'($urandom_range(1, 300)), 40, 70, 1'b0, 1'b0);
    // Drive the largest pool with 280 requests, mostly allocations.
    run_phase(CntW'(256), 280, 97, 1'b0, 1'b0);

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $display("%0d responses never arrived", expected_rsps.size());
      error_count++;
    end
    $display("Summary: %0d requests over %0d capacity settings, %0d responses checked.",
             reqs_sent, settings_count, rsps_checked);
    $display("Summary: %0d empty-pool allocs and %0d rejected frees among them.",
             empty_seen, reject_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/fla_pkg.sv
src/fla_req_if.sv
src/fla_rsp_if.sv
src/fla_ctrl.sv
src/fla_dp.sv
src/free_list_index_allocator_top.sv
test/free_list_index_allocator_top_tb.sv
